/* rtl/lbk_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbk_pkg
// Types, constants and round functions shared by the LBlock-80 cipher core.
// ----------------------------------------------------------------------------
package lbk_pkg;

   localparam int Rounds    = 32;
   localparam int HalfW     = 32;
   localparam int KeyW      = 80;
   localparam int KeyHighW  = 64;
   localparam int KeyLowW   = 16;
   localparam int RcW       = 5;
   localparam int CsrIndexW = 2;
   localparam int CsrDataW  = 64;

   localparam logic [CsrIndexW-1:0] CsrKeyHigh   = 2'd0;
   localparam logic [CsrIndexW-1:0] CsrKeyLow    = 2'd1;
   localparam logic [CsrIndexW-1:0] CsrFaultMask = 2'd2;

   localparam logic [0:9][0:15][3:0] Sbox = '{
      '{4'd14, 4'd9,  4'd15, 4'd0,  4'd13, 4'd4,  4'd10, 4'd11,
        4'd1,  4'd2,  4'd8,  4'd3,  4'd7,  4'd6,  4'd12, 4'd5},
      '{4'd4,  4'd11, 4'd14, 4'd9,  4'd15, 4'd13, 4'd0,  4'd10,
        4'd7,  4'd12, 4'd5,  4'd6,  4'd2,  4'd8,  4'd1,  4'd3},
      '{4'd1,  4'd14, 4'd7,  4'd12, 4'd15, 4'd13, 4'd0,  4'd6,
        4'd11, 4'd5,  4'd9,  4'd3,  4'd2,  4'd4,  4'd8,  4'd10},
      '{4'd7,  4'd6,  4'd8,  4'd11, 4'd0,  4'd15, 4'd3,  4'd14,
        4'd9,  4'd10, 4'd12, 4'd13, 4'd5,  4'd2,  4'd4,  4'd1},
      '{4'd14, 4'd5,  4'd15, 4'd0,  4'd7,  4'd2,  4'd12, 4'd13,
        4'd1,  4'd8,  4'd4,  4'd9,  4'd11, 4'd10, 4'd6,  4'd3},
      '{4'd2,  4'd13, 4'd11, 4'd12, 4'd15, 4'd14, 4'd0,  4'd9,
        4'd7,  4'd10, 4'd6,  4'd3,  4'd1,  4'd8,  4'd4,  4'd5},
      '{4'd11, 4'd9,  4'd4,  4'd14, 4'd0,  4'd15, 4'd10, 4'd13,
        4'd6,  4'd12, 4'd5,  4'd7,  4'd3,  4'd8,  4'd1,  4'd2},
      '{4'd13, 4'd10, 4'd15, 4'd0,  4'd14, 4'd4,  4'd9,  4'd11,
        4'd2,  4'd1,  4'd8,  4'd3,  4'd7,  4'd5,  4'd12, 4'd6},
      '{4'd8,  4'd7,  4'd14, 4'd5,  4'd15, 4'd13, 4'd0,  4'd6,
        4'd11, 4'd12, 4'd9,  4'd10, 4'd2,  4'd4,  4'd1,  4'd3},
      '{4'd11, 4'd5,  4'd15, 4'd0,  4'd7,  4'd2,  4'd9,  4'd13,
        4'd4,  4'd8,  4'd1,  4'd12, 4'd14, 4'd10, 4'd3,  4'd6}
   };

   typedef struct packed {
      logic [HalfW-1:0] left;
      logic [HalfW-1:0] right;
      logic [KeyW-1:0]  key;
   } blk_state_type;

   typedef struct packed {
      logic [HalfW-1:0] left;
      logic [HalfW-1:0] right;
   } blk_out_type;

   function automatic logic [HalfW-1:0] subst(input logic [HalfW-1:0] v);
      logic [HalfW-1:0] res;
      res = '0;
      for (int n = 0; n < 8; n++) begin
         res[4*n +: 4] = Sbox[n][v[4*n +: 4]];
      end
      return res;
   endfunction

   function automatic logic [HalfW-1:0] perm(input logic [HalfW-1:0] v);
      return ((v >> 4) & 32'h000f000f) | ((v << 4) & 32'hf000f000) |
             ((v >> 8) & 32'h00f000f0) | ((v << 8) & 32'h0f000f00);
   endfunction

   function automatic logic [KeyW-1:0] key_update(input logic [KeyW-1:0] k,
                                                  input logic [RcW-1:0]  cnt);
      logic [KeyW-1:0] r;
      r = {k[50:0], k[79:51]};
      r[79:76] = Sbox[9][r[79:76]];
      r[75:72] = Sbox[8][r[75:72]];
      r[50:46] = r[50:46] ^ cnt;
      return r;
   endfunction

endpackage

/* rtl/lblock_encrypt_with_fault.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lblock_encrypt_with_fault
// LBlock-80 encryption, one round per pipeline stage, with a fault mask
// XORed into the left half ahead of the last round's key addition.
//
//   channel  direction  ports
//   req      in         req_valid, req_stall, req_plain_left, req_plain_right
//   rsp      out        rsp_valid, rsp_stall, rsp_cipher_left, rsp_cipher_right
//   csr      in         csr_wr_en, csr_index, csr_wdata
//
// One item per cycle while the skid entry is empty; one stage per round plus
// the output register. The key travels with each item; each stage after the first updates it.
// Reset clears valid bits and the key and mask registers to zero.
// A stalled output fills one skid entry, after which the whole pipeline holds.
// ----------------------------------------------------------------------------
module lblock_encrypt_with_fault (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [lbk_pkg::HalfW-1:0]    req_plain_left,
   input  logic [lbk_pkg::HalfW-1:0]    req_plain_right,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [lbk_pkg::HalfW-1:0]    rsp_cipher_left,
   output logic [lbk_pkg::HalfW-1:0]    rsp_cipher_right,
   input  logic                         csr_wr_en,
   input  logic [lbk_pkg::CsrIndexW-1:0] csr_index,
   input  logic [lbk_pkg::CsrDataW-1:0] csr_wdata
);
   import lbk_pkg::*;

   logic [KeyHighW-1:0] key_high_ff;
   logic [KeyLowW-1:0]  key_low_ff;
   logic [HalfW-1:0]    fault_mask_ff;

   logic                advance;
   logic                stg_valid [Rounds+1];
   blk_state_type       stg_state [Rounds+1];
   blk_out_type         pipe_out;
   blk_out_type         rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff   <= '0;
         key_low_ff    <= '0;
         fault_mask_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CsrKeyHigh:   key_high_ff   <= csr_wdata;
            CsrKeyLow:    key_low_ff    <= csr_wdata[KeyLowW-1:0];
            CsrFaultMask: fault_mask_ff <= csr_wdata[HalfW-1:0];
            default: ;
         endcase
      end
   end

   assign req_stall = !advance;

   assign stg_valid[0]       = req_valid;
   assign stg_state[0].left  = req_plain_left;
   assign stg_state[0].right = req_plain_right;
   assign stg_state[0].key   = {key_high_ff, key_low_ff};

   for (genvar s = 0; s < Rounds; s++) begin : g_round
      lbk_stage u_stage (
         .clock      (clock),
         .reset      (reset),
         .enable     (advance),
         .in_valid   (stg_valid[s]),
         .in_state   (stg_state[s]),
         .round_idx  (RcW'(s)),
         .last_round (s == Rounds - 1),
         .fault_mask (fault_mask_ff),
         .out_valid  (stg_valid[s+1]),
         .out_state  (stg_state[s+1])
      );
   end

   assign pipe_out.left  = stg_state[Rounds].left;
   assign pipe_out.right = stg_state[Rounds].right;

   lbk_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stg_valid[Rounds]),
      .in_data   (pipe_out),
      .advance   (advance),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign rsp_cipher_left  = rsp_data.left;
   assign rsp_cipher_right = rsp_data.right;

endmodule

/* rtl/lbk_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbk_stage
// One registered LBlock round: key schedule step (skipped in round 0), round function, swap (not in the last round).
// ----------------------------------------------------------------------------
module lbk_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  in_valid,
   input  lbk_pkg::blk_state_type in_state,
   input  logic [lbk_pkg::RcW-1:0]   round_idx,
   input  logic                  last_round,
   input  logic [lbk_pkg::HalfW-1:0] fault_mask,
   output logic                  out_valid,
   output lbk_pkg::blk_state_type out_state
);
   import lbk_pkg::*;

   logic          valid_ff;
   blk_state_type state_ff;
   blk_state_type state_in;
   logic [KeyW-1:0]  key_cur;
   logic [HalfW-1:0] xl;
   logic [HalfW-1:0] xr;
   logic [HalfW-1:0] f;

   always_comb begin
      key_cur = (round_idx != '0) ? key_update(in_state.key, round_idx) : in_state.key;
      xr      = {in_state.right[HalfW-9:0], in_state.right[HalfW-1:HalfW-8]};
      xl      = in_state.left ^ (last_round ? fault_mask : '0);
      f       = perm(subst(xl ^ key_cur[KeyW-1:KeyW-HalfW]));
      xr      = xr ^ f;
      state_in.key = key_cur;
      if (last_round) begin
         state_in.left  = xl;
         state_in.right = xr;
      end else begin
         state_in.left  = xr;
         state_in.right = xl;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         state_ff <= state_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;

endmodule

/* rtl/lbk_out_buf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbk_out_buf
// Output register with one skid entry; holds the pipeline when the skid fills.
// ----------------------------------------------------------------------------
module lbk_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  lbk_pkg::blk_out_type in_data,
   output logic                advance,
   output logic                out_valid,
   input  logic                out_stall,
   output lbk_pkg::blk_out_type out_data
);
   import lbk_pkg::*;

   logic        out_valid_ff;
   logic        out_valid_in;
   blk_out_type out_data_ff;
   blk_out_type out_data_in;
   logic        skid_valid_ff;
   logic        skid_valid_in;
   blk_out_type skid_data_ff;
   logic        out_take;
   logic        incoming;
   logic        load_out;
   logic        load_skid;

   assign advance  = !skid_valid_ff;
   assign out_take = out_valid_ff && !out_stall;
   assign incoming = advance && in_valid;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      load_out      = 1'b0;
      load_skid     = 1'b0;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_data_in   = skid_data_ff;
            load_out      = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (incoming) begin
         if (!out_valid_ff || out_take) begin
            out_data_in  = in_data;
            load_out     = 1'b1;
            out_valid_in = 1'b1;
         end else begin
            load_skid     = 1'b1;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_data_ff <= out_data_in;
      end
      if (load_skid) begin
         skid_data_ff <= in_data;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LBlock-80 encryption pipeline with fault mask.
// A local bit-level model of the cipher predicts every ciphertext item from
// the key and mask last written. Each item that leaves the pipeline is
// compared, half by half, with the oldest prediction. The sender runs in
// random bursts and the receiver stalls in changing patterns. Register
// writes happen only while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int NUM_ROUNDS  = 32;
   localparam int LATENCY     = NUM_ROUNDS + 1;
   localparam int CYCLE_LIMIT = 300000;
   localparam int MAX_REPORTS = 100;
   localparam int PHASE_ITEMS = 320;
   localparam logic [lbk_pkg::CsrIndexW-1:0] CsrUnused = 2'd3;

   typedef struct packed {
      logic [31:0] left;
      logic [31:0] right;
   } cblock_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_plain_left;
   logic [31:0] req_plain_right;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_cipher_left;
   logic [31:0] rsp_cipher_right;
   logic        csr_wr_en;
   logic [lbk_pkg::CsrIndexW-1:0] csr_index;
   logic [lbk_pkg::CsrDataW-1:0]  csr_wdata;

   // register copies
   logic [63:0] key_hi_q;
   logic [15:0] key_lo_q;
   logic [31:0] fault_q;

   cblock_type cipher_q[$];
   int      mismatches = 0;
   int      reports    = 0;
   int      cycle_cnt  = 0;
   int      burst_left = 0;

   lblock_encrypt_with_fault i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_plain_left   (req_plain_left),
      .req_plain_right  (req_plain_right),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_cipher_left  (rsp_cipher_left),
      .rsp_cipher_right (rsp_cipher_right),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // S-box rows, nibble x of row n at bits [4x+3:4x]
   function automatic logic [63:0] sbox_row(input int n);
      case (n)
         0: return 64'h5C67_3821_BA4D_0F9E;
         1: return 64'h3182_65C7_A0DF_9EB4;
         2: return 64'hA842_395B_60DF_C7E1;
         3: return 64'h1425_DCA9_E3F0_B867;
         4: return 64'h36AB_9481_DC27_0F5E;
         5: return 64'h5481_36A7_90EF_CBD2;
         6: return 64'h2183_75C6_DAF0_E49B;
         7: return 64'h6C57_3812_B94E_0FAD;
         8: return 64'h3142_A9CB_60DF_5E78;
         default: return 64'h63AE_C184_D927_0F5B;
      endcase
   endfunction

   function automatic logic [3:0] sbox(input int n, input logic [3:0] x);
      logic [63:0] row;
      row = sbox_row(n);
      return row[4*int'(x) +: 4];
   endfunction

   function automatic logic [31:0] round_mix(input logic [31:0] v);
      logic [31:0] s;
      s = '0;
      for (int n = 0; n < 8; n++) begin
         s[4*n +: 4] = sbox(n, v[4*n +: 4]);
      end
      return {s[27:24], s[19:16], s[31:28], s[23:20],
              s[11:8],  s[3:0],   s[15:12], s[7:4]};
   endfunction

   function automatic logic [79:0] next_key(input logic [79:0] k, input int cnt);
      logic [79:0] r;
      logic [4:0]  c;
      c = cnt[4:0];
      r = {k[50:0], k[79:51]};
      r[79:76] = sbox(9, r[79:76]);
      r[75:72] = sbox(8, r[75:72]);
      r[50:46] = r[50:46] ^ c;
      return r;
   endfunction

   function automatic cblock_type lblock_encipher(input logic [31:0] pl,
                                                  input logic [31:0] pr);
      logic [79:0] k;
      logic [31:0] xl;
      logic [31:0] xr;
      logic [31:0] t;
      cblock_type  res;
      k  = {key_hi_q, key_lo_q};
      xl = pl;
      xr = pr;
      for (int rc = 0; rc < NUM_ROUNDS; rc++) begin
         if (rc > 0) k = next_key(k, rc);
         xr = {xr[23:0], xr[31:24]};
         if (rc == NUM_ROUNDS - 1) xl = xl ^ fault_q;
         xr = xr ^ round_mix(xl ^ k[79:48]);
         if (rc != NUM_ROUNDS - 1) begin
            t  = xl;
            xl = xr;
            xr = t;
         end
      end
      res.left  = xl;
      res.right = xr;
      return res;
   endfunction

   task automatic send_block(input logic [31:0] pl, input logic [31:0] pr);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_plain_left  <= pl;
      req_plain_right <= pr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      cipher_q.push_back(lblock_encipher(pl, pr));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (cipher_q.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_csr(input logic [lbk_pkg::CsrIndexW-1:0] idx,
                            input logic [63:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         lbk_pkg::CsrKeyHigh:   key_hi_q = data;
         lbk_pkg::CsrKeyLow:    key_lo_q = data[15:0];
         lbk_pkg::CsrFaultMask: fault_q  = data[31:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // zero key from reset, plaintext extremes
   task automatic test_reset_key();
      send_block(32'h0000_0000, 32'h0000_0000);
      send_block(32'hffff_ffff, 32'hffff_ffff);
      send_block(32'hffff_ffff, 32'h0000_0000);
      send_block(32'h0000_0000, 32'hffff_ffff);
   endtask

   // fault mask shows up in cipher_left since the last round does not swap
   task automatic test_fault_mask();
      logic [31:0] masks [4];
      logic [31:0] pl;
      logic [31:0] pr;
      masks = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0001, 32'h8000_0000};
      pl = $urandom;
      pr = $urandom;
      wait_idle();
      write_csr(lbk_pkg::CsrKeyHigh, rand64());
      write_csr(lbk_pkg::CsrKeyLow, rand64());
      for (int m = 0; m < 4; m++) begin
         wait_idle();
         write_csr(lbk_pkg::CsrFaultMask, {32'h0, masks[m]});
         send_block(pl, pr);
         send_block($urandom, $urandom);
      end
   endtask

   // wide writes drop upper bits, unused index is ignored
   task automatic test_csr_corners();
      wait_idle();
      write_csr(lbk_pkg::CsrKeyHigh, 64'hffff_ffff_ffff_ffff);
      write_csr(lbk_pkg::CsrKeyLow, 64'hffff_ffff_ffff_ffff);
      write_csr(lbk_pkg::CsrFaultMask, 64'hffff_ffff_0000_0000);
      send_block(32'h0000_0000, 32'hffff_ffff);
      send_block($urandom, $urandom);
      wait_idle();
      write_csr(CsrUnused, rand64());
      send_block($urandom, $urandom);
      send_block(32'hffff_ffff, 32'h0000_0000);
      wait_idle();
      write_csr(lbk_pkg::CsrKeyLow, 64'hffff_ffff_ffff_0000);
      write_csr(lbk_pkg::CsrFaultMask, 64'ha5a5_a5a5_5a5a_5a5a);
      send_block($urandom, $urandom);
      send_block($urandom, $urandom);
   endtask

   task automatic test_random_phases();
      logic [31:0] pl;
      logic [31:0] pr;
      int          sel;
      for (int p = 0; p < 6; p++) begin
         wait_idle();
         case (p)
            0: begin
               write_csr(lbk_pkg::CsrKeyHigh, 64'hffff_ffff_ffff_ffff);
               write_csr(lbk_pkg::CsrKeyLow, 64'h0000_0000_0000_ffff);
               write_csr(lbk_pkg::CsrFaultMask, 64'h0000_0000_ffff_ffff);
            end
            1: begin
               write_csr(lbk_pkg::CsrKeyHigh, 64'h0);
               write_csr(lbk_pkg::CsrKeyLow, 64'h0);
               write_csr(lbk_pkg::CsrFaultMask, rand64());
            end
            2: begin
               write_csr(lbk_pkg::CsrKeyHigh, rand64());
               write_csr(lbk_pkg::CsrKeyLow, rand64());
               write_csr(lbk_pkg::CsrFaultMask, 64'h0);
            end
            default: begin
               write_csr(lbk_pkg::CsrKeyHigh, rand64());
               write_csr(lbk_pkg::CsrKeyLow, rand64());
               write_csr(lbk_pkg::CsrFaultMask, rand64());
               if ($urandom_range(0, 1) == 0) write_csr(CsrUnused, rand64());
            end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            pl  = $urandom;
            pr  = $urandom;
            sel = $urandom_range(0, 15);
            if (sel == 0) pl = 32'h0;
            if (sel == 1) pl = 32'hffff_ffff;
            if (sel == 2) pr = 32'h0;
            if (sel == 3) pr = 32'hffff_ffff;
            send_block(pl, pr);
         end
      end
   endtask

   // result check and receiver stall pattern
   always @(posedge clock) begin : rsp_side
      cblock_type exp_b;
      int       stall_mode;
      int       stall_tick;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (cipher_q.size() == 0) begin
            mismatches++;
            if (reports++ < MAX_REPORTS)
               $display("%0t unexpected item: actual %h %h", $time,
                        rsp_cipher_left, rsp_cipher_right);
         end else begin
            exp_b = cipher_q.pop_front();
            if (rsp_cipher_left !== exp_b.left) begin
               mismatches++;
               if (reports++ < MAX_REPORTS)
                  $display("%0t cipher_left mismatch: expected %h actual %h", $time,
                           exp_b.left, rsp_cipher_left);
            end
            if (rsp_cipher_right !== exp_b.right) begin
               mismatches++;
               if (reports++ < MAX_REPORTS)
                  $display("%0t cipher_right mismatch: expected %h actual %h", $time,
                           exp_b.right, rsp_cipher_right);
            end
         end
      end
      if (stall_tick % 300 == 0) stall_mode = $urandom_range(0, 3);
      stall_tick++;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ((stall_tick % 7) < 3);
      endcase
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_plain_left  <= '0;
      req_plain_right <= '0;
      csr_wr_en       <= 1'b0;
      csr_index       <= lbk_pkg::CsrKeyHigh;
      csr_wdata       <= '0;
      key_hi_q = '0;
      key_lo_q = '0;
      fault_q  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_key();
      test_fault_mask();
      test_csr_corners();
      test_random_phases();
      wait_idle();
      repeat (2 * LATENCY) @(posedge clock);
      if (mismatches == 0 && cipher_q.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
